// File: rtl/stt_pkg.sv
package stt_pkg;

   // table geometry
   localparam int SLOTS       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(SLOTS + 1);
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

   // field widths
   localparam int REQ_W    = 2;
   localparam int ID_W     = 8;
   localparam int DELAY_W  = 16;
   localparam int STATUS_W = 3;

   // request codes
   localparam logic [REQ_W-1:0] REQ_START = 2'd0;
   localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_INIT = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NO_START = 3'd4;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   // one timer entry as stored in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [DELAY_W-1:0] reload;
      logic [DELAY_W-1:0] count;
      logic               periodic;
   } slot_entry_type;

   // slot memory access from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      slot_entry_type    wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } ram_req_type;

   // one result item
   typedef struct packed {
      logic                kind;
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     fired_id;
      logic                fired;
      logic                last;
   } rsp_type;

endpackage

// File: rtl/software_timer_table.sv
// A tick, or a start or stop that must search the table, walks all SLOTS entries of
// the slot memory, one read a cycle except while the result side stalls the walk.
// Other requests skip the walk and go straight to their closing result item.
// One item is in work at a time.
// A new request is accepted only after the closing item of the last one is given.
// Reset (synchronous, active high) empties the table, clears enable and started.
module software_timer_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [stt_pkg::REQ_W-1:0]    req_type,
   input  logic [stt_pkg::ID_W-1:0]     req_task_id,
   input  logic [stt_pkg::DELAY_W-1:0]  req_delay_ticks,
   input  logic                         req_periodic,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_kind,
   output logic [stt_pkg::STATUS_W-1:0] rsp_status,
   output logic [stt_pkg::ID_W-1:0]     rsp_fired_id,
   output logic                         rsp_fired,
   output logic                         rsp_last
);
   import stt_pkg::*;

   logic                              enable_ff;
   logic                              enable_in;
   ram_req_type                       ram_req;
   logic [$bits(slot_entry_type)-1:0] ram_rd_raw;
   slot_entry_type                    ram_rd_data;
   logic                              out_free;
   logic                              rsp_push;
   rsp_type                           rsp_data;

   // enable register
   assign enable_in = csr_wr_en ? csr_wr_data : enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   stt_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = ram_rd_raw;

   stt_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .enable          (enable_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_task_id     (req_task_id),
      .req_delay_ticks (req_delay_ticks),
      .req_periodic    (req_periodic),
      .ram_req         (ram_req),
      .ram_rd_data     (ram_rd_data),
      .out_free        (out_free),
      .rsp_push        (rsp_push),
      .rsp_data        (rsp_data)
   );

   stt_rsp u_rsp (
      .clock        (clock),
      .reset        (reset),
      .push         (rsp_push),
      .push_data    (rsp_data),
      .out_free     (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_kind     (rsp_kind),
      .rsp_status   (rsp_status),
      .rsp_fired_id (rsp_fired_id),
      .rsp_fired    (rsp_fired),
      .rsp_last     (rsp_last)
   );

endmodule

// File: rtl/stt_ram.sv
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/stt_rsp.sv
module stt_rsp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  stt_pkg::rsp_type              push_data,
   output logic                          out_free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [stt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [stt_pkg::ID_W-1:0]      rsp_fired_id,
   output logic                          rsp_fired,
   output logic                          rsp_last
);
   import stt_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // the register can take a new item when empty or draining this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // hold control under reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = data_ff.kind;
   assign rsp_status   = data_ff.status;
   assign rsp_fired_id = data_ff.fired_id;
   assign rsp_fired    = data_ff.fired;
   assign rsp_last     = data_ff.last;

endmodule

// File: rtl/stt_seq.sv
module stt_seq (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [stt_pkg::REQ_W-1:0]    req_type,
   input  logic [stt_pkg::ID_W-1:0]     req_task_id,
   input  logic [stt_pkg::DELAY_W-1:0]  req_delay_ticks,
   input  logic                         req_periodic,
   output stt_pkg::ram_req_type         ram_req,
   input  stt_pkg::slot_entry_type      ram_rd_data,
   input  logic                         out_free,
   output logic                         rsp_push,
   output stt_pkg::rsp_type             rsp_data
);
   import stt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               proc_valid_ff, proc_valid_in;
   logic [SLOT_W-1:0]  proc_idx_ff, proc_idx_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic               started_ff, started_in;
   logic [REQ_W-1:0]   req_type_ff, req_type_in;
   logic [ID_W-1:0]    req_id_ff, req_id_in;
   logic [DELAY_W-1:0] req_delay_ff, req_delay_in;
   logic               req_per_ff, req_per_in;
   logic               dup_ff, dup_in;
   logic               free_found_ff, free_found_in;
   logic [SLOT_W-1:0]  free_idx_ff, free_idx_in;
   logic               match_found_ff, match_found_in;
   logic [SLOT_W-1:0]  match_idx_ff, match_idx_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic [NUM_W-1:0]   n_ff, n_in;

   logic proc_live;
   logic expire;
   logic report;
   logic step;
   logic go_scan;
   logic issue;

   assign req_ready = (state_ff == ST_IDLE);

   // decode the entry that the memory returned for the slot under work
   assign proc_live = proc_valid_ff && valid_ff[proc_idx_ff];
   assign expire    = (req_type_ff == REQ_TICK) && proc_live
                      && (ram_rd_data.count == DELAY_W'(1));
   assign report    = expire && (n_ff < NUM_W'(MAX_RESULTS));
   // stall the walk while an earlier expiry cannot leave
   assign step      = (state_ff == ST_SCAN) && (!(report && pend_valid_ff) || out_free);
   assign issue     = idx_ff < CNT_W'(SLOTS);
   assign go_scan   = (req_type == REQ_TICK)
                      || (enable && (((req_type == REQ_START) && (req_delay_ticks != '0))
                                     || ((req_type == REQ_STOP) && started_ff)));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      proc_valid_in  = proc_valid_ff;
      proc_idx_in    = proc_idx_ff;
      valid_in       = valid_ff;
      started_in     = started_ff;
      req_type_in    = req_type_ff;
      req_id_in      = req_id_ff;
      req_delay_in   = req_delay_ff;
      req_per_in     = req_per_ff;
      dup_in         = dup_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      pend_valid_in  = pend_valid_ff;
      pend_id_in     = pend_id_ff;
      n_in           = n_ff;
      ram_req        = '0;
      rsp_push       = 1'b0;
      rsp_data       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // latch the item and reset the walk
            if (req_valid) begin
               req_type_in    = req_type;
               req_id_in      = req_task_id;
               req_delay_in   = req_delay_ticks;
               req_per_in     = req_periodic;
               idx_in         = '0;
               proc_valid_in  = 1'b0;
               dup_in         = 1'b0;
               free_found_in  = 1'b0;
               match_found_in = 1'b0;
               pend_valid_in  = 1'b0;
               n_in           = '0;
               state_in       = go_scan ? ST_SCAN : ST_FINISH;
            end
         end

         ST_SCAN: begin
            if (step) begin
               // issue the read of the next slot
               ram_req.rd_en   = issue;
               ram_req.rd_addr = idx_ff[SLOT_W-1:0];
               proc_valid_in   = issue;
               proc_idx_in     = idx_ff[SLOT_W-1:0];
               if (issue) begin
                  idx_in = idx_ff + CNT_W'(1);
               end else begin
                  state_in = ST_FINISH;
               end

               // work on the slot whose data is back
               if (proc_valid_ff) begin
                  case (req_type_ff)
                     REQ_TICK: begin
                        if (proc_live) begin
                           ram_req.wr_en   = 1'b1;
                           ram_req.wr_addr = proc_idx_ff;
                           ram_req.wr_data = ram_rd_data;
                           ram_req.wr_data.count = ram_rd_data.count - DELAY_W'(1);
                           if (expire) begin
                              if (ram_rd_data.periodic) begin
                                 ram_req.wr_data.count = ram_rd_data.reload;
                              end else begin
                                 valid_in[proc_idx_ff] = 1'b0;
                              end
                           end
                           if (report) begin
                              // release the held expiry, hold this one
                              if (pend_valid_ff) begin
                                 rsp_push          = 1'b1;
                                 rsp_data.kind     = KIND_EXPIRY;
                                 rsp_data.status   = STAT_OK;
                                 rsp_data.fired_id = pend_id_ff;
                                 rsp_data.fired    = 1'b1;
                                 rsp_data.last     = 1'b0;
                              end
                              pend_valid_in = 1'b1;
                              pend_id_in    = ram_rd_data.id;
                              n_in          = n_ff + NUM_W'(1);
                           end
                        end
                     end
                     REQ_START: begin
                        if (proc_live && (ram_rd_data.id == req_id_ff)) begin
                           dup_in = 1'b1;
                        end
                        if (!valid_ff[proc_idx_ff] && !free_found_ff) begin
                           free_found_in = 1'b1;
                           free_idx_in   = proc_idx_ff;
                        end
                     end
                     REQ_STOP: begin
                        if (proc_live && (ram_rd_data.id == req_id_ff) && !match_found_ff) begin
                           match_found_in = 1'b1;
                           match_idx_in   = proc_idx_ff;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         ST_FINISH: begin
            // give the closing item and commit the request
            if (out_free) begin
               rsp_push          = 1'b1;
               state_in          = ST_IDLE;
               rsp_data.kind     = KIND_STATUS;
               rsp_data.status   = STAT_OK;
               rsp_data.fired_id = '0;
               rsp_data.fired    = 1'b0;
               rsp_data.last     = 1'b1;
               case (req_type_ff)
                  REQ_TICK: begin
                     if (pend_valid_ff) begin
                        rsp_data.kind     = KIND_EXPIRY;
                        rsp_data.fired_id = pend_id_ff;
                        rsp_data.fired    = 1'b1;
                     end
                  end
                  REQ_START: begin
                     if (!enable) begin
                        rsp_data.status = STAT_NOT_INIT;
                     end else if ((req_delay_ff == '0) || dup_ff) begin
                        rsp_data.status = STAT_INVALID;
                     end else if (!free_found_ff) begin
                        rsp_data.status = STAT_FULL;
                     end else begin
                        ram_req.wr_en            = 1'b1;
                        ram_req.wr_addr          = free_idx_ff;
                        ram_req.wr_data.id       = req_id_ff;
                        ram_req.wr_data.reload   = req_delay_ff;
                        ram_req.wr_data.count    = req_delay_ff;
                        ram_req.wr_data.periodic = req_per_ff;
                        valid_in[free_idx_ff]    = 1'b1;
                        started_in               = 1'b1;
                     end
                  end
                  REQ_STOP: begin
                     if (!enable) begin
                        rsp_data.status = STAT_NOT_INIT;
                     end else if (!started_ff) begin
                        rsp_data.status = STAT_NO_START;
                     end else if (!match_found_ff) begin
                        rsp_data.status = STAT_INVALID;
                     end else begin
                        valid_in[match_idx_ff] = 1'b0;
                     end
                  end
                  default: begin
                     if (!enable) begin
                        rsp_data.status = STAT_NOT_INIT;
                     end else begin
                        valid_in = '0;
                     end
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         proc_valid_ff  <= 1'b0;
         valid_ff       <= '0;
         started_ff     <= 1'b0;
         dup_ff         <= 1'b0;
         free_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         pend_valid_ff  <= 1'b0;
         n_ff           <= '0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         proc_valid_ff  <= proc_valid_in;
         valid_ff       <= valid_in;
         started_ff     <= started_in;
         dup_ff         <= dup_in;
         free_found_ff  <= free_found_in;
         match_found_ff <= match_found_in;
         pend_valid_ff  <= pend_valid_in;
         n_ff           <= n_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      proc_idx_ff  <= proc_idx_in;
      req_type_ff  <= req_type_in;
      req_id_ff    <= req_id_in;
      req_delay_ff <= req_delay_in;
      req_per_ff   <= req_per_in;
      free_idx_ff  <= free_idx_in;
      match_idx_ff <= match_idx_in;
      pend_id_ff   <= pend_id_in;
   end

endmodule
